### design/sm4_cbc_encryptor_assert.svh
// assertion macros for the sm4 cbc encryptor
// used by the top level only, no other dependencies
`ifndef SM4_CBC_ENCRYPTOR_ASSERT_SVH
`define SM4_CBC_ENCRYPTOR_ASSERT_SVH

// same-cycle implication
`define SM4CBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sm4 cbc assertion failed");

// next-cycle implication
`define SM4CBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sm4 cbc assertion failed");

`endif

### design/sm4cbc_pkg.sv
// shared types, constants and round functions of the sm4 cbc encryptor
// no dependencies
package sm4cbc_pkg;

    localparam int BLK_W     = 128;
    localparam int HALF_W    = 64;
    localparam int WORD_W    = 32;
    localparam int NUM_RND   = 32;
    localparam int RND_W     = 5;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd3;

    localparam logic [CNT_W-1:0] FULL_BYTES = 5'd16;
    localparam logic [BLK_W-1:0] PAD_BLOCK  = {16{8'h10}};

    localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
    localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
    localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
    localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic             load;
        logic             use_iv;
        logic             kinit;
        logic             kstep;
        logic             estep;
        logic             out_write;
        logic             out_final;
        logic             pad_load;
        logic [RND_W-1:0] round;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic extra;
        logic last;
    } t_dp_stat;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic t_word tau(input t_word v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic t_word t_enc(input t_word v);
        t_word b;
        b = tau(v);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic t_word t_key(input t_word v);
        t_word b;
        b = tau(v);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // ck byte j of round i is (4i+j)*7 mod 256
    function automatic t_word ck(input logic [RND_W-1:0] i);
        t_word      w;
        logic [7:0] n;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            n = {1'b0, i, 2'(j)};
            w[31-8*j -: 8] = (n << 3) - n;
        end
        return w;
    endfunction

endpackage

### design/sm4cbc_intf.sv
// valid/ready channel interfaces for plaintext and ciphertext words
// depends on sm4cbc_pkg
interface sm4cbc_in_if;
    logic                            valid;
    logic                            ready;
    logic [sm4cbc_pkg::HALF_W-1:0]   plain_high;
    logic [sm4cbc_pkg::HALF_W-1:0]   plain_low;
    logic [sm4cbc_pkg::CNT_W-1:0]    valid_bytes;
    logic                            last_block;

    modport source (output valid, output plain_high, output plain_low,
                    output valid_bytes, output last_block, input ready);
    modport sink   (input valid, input plain_high, input plain_low,
                    input valid_bytes, input last_block, output ready);
endinterface

interface sm4cbc_out_if;
    logic                            valid;
    logic                            ready;
    logic [sm4cbc_pkg::HALF_W-1:0]   cipher_high;
    logic [sm4cbc_pkg::HALF_W-1:0]   cipher_low;
    logic                            last_result;

    modport source (output valid, output cipher_high, output cipher_low,
                    output last_result, input ready);
    modport sink   (input valid, input cipher_high, input cipher_low,
                    input last_result, output ready);
endinterface

### design/sm4cbc_ctrl.sv
// controller: sequences key expansion, rounds, output and padding block
// depends on sm4cbc_pkg
module sm4cbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_accept,
    input  sm4cbc_pkg::t_dp_stat  i_stat,
    output logic                  o_ready,
    output sm4cbc_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_KEXP = 2'd1;
    localparam logic [1:0] S_ENC  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [sm4cbc_pkg::RND_W-1:0] LAST_RND =
        sm4cbc_pkg::RND_W'(sm4cbc_pkg::NUM_RND - 1);

    logic [1:0]                   r_state, n_state;
    logic [sm4cbc_pkg::RND_W-1:0] r_round, n_round;
    logic                         r_keys_ready, n_keys_ready;
    logic                         r_msg_start, n_msg_start;
    logic                         r_second, n_second;

    always_comb begin
        n_state      = r_state;
        n_round      = r_round;
        n_keys_ready = r_keys_ready;
        n_msg_start  = r_msg_start;
        n_second     = r_second;
        o_cmd        = '0;
        o_cmd.round  = r_round;
        o_ready      = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.use_iv = r_msg_start;
                    o_cmd.kinit  = !r_keys_ready;
                    n_msg_start  = 1'b0;
                    n_second     = 1'b0;
                    n_round      = '0;
                    n_state      = r_keys_ready ? S_ENC : S_KEXP;
                end
            end
            S_KEXP: begin
                o_cmd.kstep = 1'b1;
                n_round     = r_round + 1'b1;
                if (r_round == LAST_RND) begin
                    n_keys_ready = 1'b1;
                    n_state      = S_ENC;
                end
            end
            S_ENC: begin
                o_cmd.estep = 1'b1;
                n_round     = r_round + 1'b1;
                if (r_round == LAST_RND) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.out_final = i_stat.last && !(i_stat.extra && !r_second);
                if (i_stat.out_free) begin
                    o_cmd.out_write = 1'b1;
                    if (i_stat.extra && !r_second) begin
                        // full last block: follow with a padding block
                        o_cmd.pad_load = 1'b1;
                        n_second       = 1'b1;
                        n_round        = '0;
                        n_state        = S_ENC;
                    end else begin
                        n_msg_start = i_stat.last;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_keys_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_round      <= '0;
            r_keys_ready <= 1'b0;
            r_msg_start  <= 1'b1;
            r_second     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_round      <= n_round;
            r_keys_ready <= n_keys_ready;
            r_msg_start  <= n_msg_start;
            r_second     <= n_second;
        end
    end

endmodule

### design/sm4cbc_datapath.sv
// datapath: config registers, key schedule, round unit, chaining and output word
// depends on sm4cbc_pkg and sm4cbc_out_if
module sm4cbc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sm4cbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sm4cbc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [sm4cbc_pkg::HALF_W-1:0]       i_plain_high,
    input  logic [sm4cbc_pkg::HALF_W-1:0]       i_plain_low,
    input  logic [sm4cbc_pkg::CNT_W-1:0]        i_valid_bytes,
    input  logic                                i_last_block,
    input  sm4cbc_pkg::t_dp_cmd                 i_cmd,
    output sm4cbc_pkg::t_dp_stat                o_stat,
    sm4cbc_out_if.source                        o_blk
);

    logic [sm4cbc_pkg::HALF_W-1:0] r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic [sm4cbc_pkg::HALF_W-1:0] r_chain_high, r_chain_low;
    sm4cbc_pkg::t_word             r_x [4];
    sm4cbc_pkg::t_word             r_k [4];
    sm4cbc_pkg::t_word             r_rk [sm4cbc_pkg::NUM_RND];
    logic                          r_last, r_extra;
    logic                          r_out_valid;
    logic [sm4cbc_pkg::HALF_W-1:0] r_out_high, r_out_low;
    logic                          r_out_last;

    logic [sm4cbc_pkg::CNT_W-1:0]  v_sat;
    logic [7:0]                    pad_val;
    logic [sm4cbc_pkg::BLK_W-1:0]  blk, chain_src, result;
    sm4cbc_pkg::t_word             nx, nk;

    // pkcs7 fill of the input word
    always_comb begin
        v_sat   = (i_valid_bytes > sm4cbc_pkg::FULL_BYTES) ?
                  sm4cbc_pkg::FULL_BYTES : i_valid_bytes;
        pad_val = 8'(sm4cbc_pkg::FULL_BYTES - v_sat);
        blk     = {i_plain_high, i_plain_low};
        for (int i = 0; i < 16; i++) begin
            if (i_last_block && (sm4cbc_pkg::CNT_W'(i) >= v_sat)) begin
                blk[sm4cbc_pkg::BLK_W-1-8*i -: 8] = pad_val;
            end
        end
    end

    assign chain_src = i_cmd.use_iv ? {r_iv_high, r_iv_low} : {r_chain_high, r_chain_low};
    assign result    = {r_x[3], r_x[2], r_x[1], r_x[0]};

    assign nx = r_x[0] ^ sm4cbc_pkg::t_enc(r_x[1] ^ r_x[2] ^ r_x[3] ^ r_rk[i_cmd.round]);
    assign nk = r_k[0] ^ sm4cbc_pkg::t_key(r_k[1] ^ r_k[2] ^ r_k[3] ^
                                           sm4cbc_pkg::ck(i_cmd.round));

    assign o_stat.out_free = !r_out_valid || o_blk.ready;
    assign o_stat.extra    = r_extra;
    assign o_stat.last     = r_last;

    assign o_blk.valid       = r_out_valid;
    assign o_blk.cipher_high = r_out_high;
    assign o_blk.cipher_low  = r_out_low;
    assign o_blk.last_result = r_out_last;

    // config, chaining and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_iv_high    <= '0;
            r_iv_low     <= '0;
            r_chain_high <= '0;
            r_chain_low  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sm4cbc_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    sm4cbc_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    sm4cbc_pkg::CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                    sm4cbc_pkg::CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_write) begin
                r_chain_high <= result[sm4cbc_pkg::BLK_W-1 -: sm4cbc_pkg::HALF_W];
                r_chain_low  <= result[sm4cbc_pkg::HALF_W-1:0];
                r_out_valid  <= 1'b1;
            end else if (o_blk.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // round state, key schedule and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            {r_x[0], r_x[1], r_x[2], r_x[3]} <= blk ^ chain_src;
            r_last  <= i_last_block;
            r_extra <= i_last_block && (i_valid_bytes >= sm4cbc_pkg::FULL_BYTES);
        end else if (i_cmd.pad_load) begin
            {r_x[0], r_x[1], r_x[2], r_x[3]} <= sm4cbc_pkg::PAD_BLOCK ^ result;
        end else if (i_cmd.estep) begin
            r_x[0] <= r_x[1];
            r_x[1] <= r_x[2];
            r_x[2] <= r_x[3];
            r_x[3] <= nx;
        end
        if (i_cmd.kinit) begin
            r_k[0] <= r_key_high[63:32] ^ sm4cbc_pkg::FK0;
            r_k[1] <= r_key_high[31:0]  ^ sm4cbc_pkg::FK1;
            r_k[2] <= r_key_low[63:32]  ^ sm4cbc_pkg::FK2;
            r_k[3] <= r_key_low[31:0]   ^ sm4cbc_pkg::FK3;
        end else if (i_cmd.kstep) begin
            r_k[0] <= r_k[1];
            r_k[1] <= r_k[2];
            r_k[2] <= r_k[3];
            r_k[3] <= nk;
            r_rk[i_cmd.round] <= nk;
        end
        if (i_cmd.out_write) begin
            r_out_high <= result[sm4cbc_pkg::BLK_W-1 -: sm4cbc_pkg::HALF_W];
            r_out_low  <= result[sm4cbc_pkg::HALF_W-1:0];
            r_out_last <= i_cmd.out_final;
        end
    end

endmodule

### design/sm4_cbc_encryptor.sv
// channel   dir  handshake      payload
// i_blk     in   valid/ready    plain_high, plain_low, valid_bytes, last_block
// o_blk     out  valid/ready    cipher_high, cipher_low, last_result
// cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data (key and iv halves)
//
// one word: accept, 32 rounds of the shared round unit, finish
// the first word after a config write adds the key schedule
// a full last block adds a padding block, run through the rounds and finish
// the finish step waits while the output register still holds an untaken word
// reset is synchronous active low; key, iv and chaining registers clear to zero
// top level: controller plus datapath; depends on sm4cbc_pkg, interfaces, assert macros
`include "sm4_cbc_encryptor_assert.svh"

module sm4_cbc_encryptor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sm4cbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sm4cbc_pkg::CFG_W-1:0]        i_cfg_data,
    sm4cbc_in_if.sink                           i_blk,
    sm4cbc_out_if.source                        o_blk
);

    sm4cbc_pkg::t_dp_cmd  cmd;
    sm4cbc_pkg::t_dp_stat stat;
    logic                 ready;
    logic                 accept;

    assign i_blk.ready = ready;
    assign accept      = i_blk.valid && ready;

    sm4cbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_accept (accept),
        .i_stat   (stat),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    sm4cbc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_plain_high  (i_blk.plain_high),
        .i_plain_low   (i_blk.plain_low),
        .i_valid_bytes (i_blk.valid_bytes),
        .i_last_block  (i_blk.last_block),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_blk         (o_blk)
    );

    `SM4CBC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_blk.ready)
    `SM4CBC_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, cmd.out_write, stat.out_free)
    `SM4CBC_ASSERT_NXT(a_word_shown, i_clk, i_rst_n, cmd.out_write, o_blk.valid)

endmodule

### tb/tb_sm4_cbc_encryptor.sv
// self-checking testbench for the sm4 cbc encryptor with pkcs7 padding
// drives plaintext words and key/iv writes, predicts every ciphertext word internally
// depends on sm4cbc_pkg, sm4cbc_intf and the sm4_cbc_encryptor top level
module tb_sm4_cbc_encryptor;

    localparam int HW = sm4cbc_pkg::HALF_W;
    localparam int CW = sm4cbc_pkg::CNT_W;
    localparam int IW = sm4cbc_pkg::CFG_IDX_W;
    localparam int unsigned WATCHDOG_CYCLES = 1_500_000;
    localparam int RANDOM_WORDS = 1900;

    localparam logic [IW-1:0] REG_IDX [4] = '{
        sm4cbc_pkg::CFG_KEY_HIGH, sm4cbc_pkg::CFG_KEY_LOW,
        sm4cbc_pkg::CFG_IV_HIGH, sm4cbc_pkg::CFG_IV_LOW
    };

    localparam logic [31:0] FK_0 = 32'ha3b1bac6;
    localparam logic [31:0] FK_1 = 32'h56aa3350;
    localparam logic [31:0] FK_2 = 32'h677d9197;
    localparam logic [31:0] FK_3 = 32'hb27022dc;
    localparam logic [127:0] PAD_WORD = {16{8'h10}};
    localparam logic [HW-1:0] ONES = '1;

    localparam logic [0:255][7:0] SBOX_ROM = {
        256'hd690e9fecce13db716b614c228fb2c05_2b679a762abe04c3aa44132649860699,
        256'h9c4250f491ef987a33540b43edcfac62_e4b31ca9c908e89580df94fa758f3fa6,
        256'h4707a7fcf37317ba83593c19e6854fa8_686b81b27164da8bf8eb0f4b70569d35,
        256'h1e240e5e6358d1a225227c3b01217887_d40046579fd327524c3602e7a0c4c89e,
        256'heabf8ad240c738b5a3f7f2cef96115a1_e0ae5da49b341a55ad933230f58cb1e3,
        256'h1df6e22e8266ca60c02923ab0d534e6f_d5db3745defd8e2f03ff6a726d6c5b51,
        256'h8d1baf92bbddbc7f11d95c411f105ad8_0ac13188a5cd7bbd2d74d012b8e5b4b0,
        256'h8969974a0c96777e65b9f109c56ec684_18f07dec3adc4d2079ee5f3ed7cb3948
    };

    typedef struct {
        logic [HW-1:0] hi;
        logic [HW-1:0] lo;
        logic [CW-1:0] nbytes;
        logic          last;
    } t_plain_word;

    typedef struct {
        logic [HW-1:0] hi;
        logic [HW-1:0] lo;
        logic          last;
    } t_cipher_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [IW-1:0] cfg_idx;
    logic [sm4cbc_pkg::CFG_W-1:0] cfg_data;

    sm4cbc_in_if  blk_in ();
    sm4cbc_out_if blk_out ();

    sm4_cbc_encryptor uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_blk      (blk_in),
        .o_blk      (blk_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [HW-1:0]  key_hi_cfg, key_lo_cfg, iv_hi_cfg, iv_lo_cfg;
    logic [31:0]    rk_sched [32];
    logic           keys_valid;
    logic           msg_first;
    logic [127:0]   chain_blk;
    t_cipher_word   pending_cipher [$];
    t_cipher_word   head_w;

    int          mismatches = 0;
    int unsigned cycle_cnt = 0;
    bit          no_idle = 1'b0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_bytes(input logic [31:0] v);
        return {SBOX_ROM[v[31:24]], SBOX_ROM[v[23:16]], SBOX_ROM[v[15:8]], SBOX_ROM[v[7:0]]};
    endfunction

    function automatic logic [31:0] lin_round(input logic [31:0] v);
        logic [31:0] b;
        b = sub_bytes(v);
        return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
    endfunction

    function automatic logic [31:0] lin_sched(input logic [31:0] v);
        logic [31:0] b;
        b = sub_bytes(v);
        return b ^ rol32(b, 13) ^ rol32(b, 23);
    endfunction

    function automatic logic [31:0] ck_word(input int i);
        logic [31:0] w;
        for (int j = 0; j < 4; j++) w[31-8*j -: 8] = 8'((4 * i + j) * 7);
        return w;
    endfunction

    function automatic logic [HW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_plain_word make_word(input logic [HW-1:0] hi, input logic [HW-1:0] lo,
                                              input int nb, input logic last);
        t_plain_word w;
        w.hi = hi;
        w.lo = lo;
        w.nbytes = CW'(nb);
        w.last = last;
        return w;
    endfunction

    task automatic expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] nk;
        k[0] = key_hi_cfg[63:32] ^ FK_0;
        k[1] = key_hi_cfg[31:0] ^ FK_1;
        k[2] = key_lo_cfg[63:32] ^ FK_2;
        k[3] = key_lo_cfg[31:0] ^ FK_3;
        for (int i = 0; i < 32; i++) begin
            nk = k[0] ^ lin_sched(k[1] ^ k[2] ^ k[3] ^ ck_word(i));
            rk_sched[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
        keys_valid = 1'b1;
    endtask

    task automatic encrypt_push(input logic [127:0] pt, input logic fin);
        logic [31:0] x [4];
        logic [31:0] nx;
        t_cipher_word c;
        pt = pt ^ chain_blk;
        x[0] = pt[127:96];
        x[1] = pt[95:64];
        x[2] = pt[63:32];
        x[3] = pt[31:0];
        for (int i = 0; i < 32; i++) begin
            nx = x[0] ^ lin_round(x[1] ^ x[2] ^ x[3] ^ rk_sched[i]);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        chain_blk = {x[3], x[2], x[1], x[0]};
        c.hi = chain_blk[127:64];
        c.lo = chain_blk[63:0];
        c.last = fin;
        pending_cipher.push_back(c);
    endtask

    task automatic predict_cipher_words(input t_plain_word w);
        logic [127:0] blk;
        int nb;
        if (!keys_valid) expand_round_keys();
        if (msg_first) begin
            chain_blk = {iv_hi_cfg, iv_lo_cfg};
            msg_first = 1'b0;
        end
        blk = {w.hi, w.lo};
        if (!w.last) begin
            encrypt_push(blk, 1'b0);
        end else begin
            msg_first = 1'b1;
            nb = (w.nbytes > 16) ? 16 : int'(w.nbytes);
            if (nb == 16) begin
                encrypt_push(blk, 1'b0);
                encrypt_push(PAD_WORD, 1'b1);
            end else begin
                for (int i = nb; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - nb);
                encrypt_push(blk, 1'b1);
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_block(input t_plain_word w);
        if (!no_idle && $urandom_range(0, 99) < 37) begin
            blk_in.valid = 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
        blk_in.valid = 1'b1;
        blk_in.plain_high = w.hi;
        blk_in.plain_low = w.lo;
        blk_in.valid_bytes = w.nbytes;
        blk_in.last_block = w.last;
        do @(posedge i_clk); while (!blk_in.ready);
        predict_cipher_words(w);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        blk_in.valid = 1'b0;
        @(negedge i_clk);
        while (pending_cipher.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [3:0] mask, input logic [HW-1:0] kh,
                               input logic [HW-1:0] kl, input logic [HW-1:0] ih,
                               input logic [HW-1:0] il);
        logic [HW-1:0] vals [4];
        vals = '{kh, kl, ih, il};
        wait_drained();
        for (int r = 0; r < 4; r++) begin
            if (mask[r]) begin
                cfg_we = 1'b1;
                cfg_idx = REG_IDX[r];
                cfg_data = vals[r];
                case (REG_IDX[r])
                    sm4cbc_pkg::CFG_KEY_HIGH: key_hi_cfg = vals[r];
                    sm4cbc_pkg::CFG_KEY_LOW:  key_lo_cfg = vals[r];
                    sm4cbc_pkg::CFG_IV_HIGH:  iv_hi_cfg = vals[r];
                    default:                  iv_lo_cfg = vals[r];
                endcase
                keys_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        cfg_we = 1'b0;
    endtask

    task automatic test_reset_state();
        send_block(make_word(64'h0123456789abcdef, 64'hfedcba9876543210, 16, 1'b1));
        send_block(make_word(rand64(), rand64(), 0, 1'b1));
    endtask

    task automatic test_field_extremes();
        load_config(4'hf, ONES, ONES, ONES, ONES);
        send_block(make_word(ONES, ONES, 31, 1'b0));
        send_block(make_word(ONES, ONES, 16, 1'b1));
        load_config(4'hf, '0, '0, '0, '0);
        send_block(make_word('0, '0, 0, 1'b0));
        send_block(make_word('0, '0, 0, 1'b1));
    endtask

    task automatic test_padding_rules();
        load_config(4'hf, rand64(), rand64(), rand64(), rand64());
        send_block(make_word(rand64(), rand64(), 1, 1'b1));
        send_block(make_word(rand64(), rand64(), 15, 1'b1));
        send_block(make_word(rand64(), rand64(), 8, 1'b1));
        send_block(make_word(rand64(), rand64(), 17, 1'b1));
        send_block(make_word(rand64(), rand64(), 31, 1'b1));
        send_block(make_word(rand64(), rand64(), 5, 1'b0));
        send_block(make_word(rand64(), rand64(), 7, 1'b1));
    endtask

    // new iv mid-message must wait for the next message, key applies at once
    task automatic test_midmessage_config();
        send_block(make_word(rand64(), rand64(), 16, 1'b0));
        load_config(4'b1100, '0, '0, rand64(), rand64());
        send_block(make_word(rand64(), rand64(), 3, 1'b0));
        load_config(4'b0010, '0, rand64(), '0, '0);
        send_block(make_word(rand64(), rand64(), 16, 1'b1));
        send_block(make_word(rand64(), rand64(), 3, 1'b1));
    endtask

    task automatic test_drain_pause();
        send_block(make_word(rand64(), rand64(), 16, 1'b0));
        send_block(make_word(rand64(), rand64(), 0, 1'b0));
        send_block(make_word(rand64(), rand64(), 12, 1'b0));
        wait_drained();
        send_block(make_word(rand64(), rand64(), 9, 1'b1));
    endtask

    task automatic test_random_traffic();
        int phase;
        int sent;
        int len;
        int nb;
        int pick;
        phase = 0;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case (phase)
                0: load_config(4'hf, ONES, ONES, ONES, ONES);
                1: load_config(4'hf, '0, '0, '0, '0);
                default: load_config(4'($urandom_range(1, 15)), rand64(), rand64(),
                                     rand64(), rand64());
            endcase
            no_idle = (phase == 4 || phase == 5);
            repeat ($urandom_range(3, 12)) begin
                len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 16);
                for (int b = 1; b <= len; b++) begin
                    pick = $urandom_range(0, 9);
                    if (b < len)        nb = $urandom_range(0, 31);
                    else if (pick == 0) nb = 0;
                    else if (pick == 1) nb = 16;
                    else if (pick == 2) nb = $urandom_range(17, 31);
                    else                nb = $urandom_range(1, 15);
                    send_block(make_word(rand64(), rand64(), nb, b == len));
                    sent++;
                end
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        blk_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            blk_out.ready = no_idle || ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && blk_out.valid && blk_out.ready) begin
            if (pending_cipher.size() == 0) begin
                mismatches++;
                $display("%0t unexpected word: expected none actual %h_%h last %b", $time,
                         blk_out.cipher_high, blk_out.cipher_low, blk_out.last_result);
            end else begin
                head_w = pending_cipher.pop_front();
                if (blk_out.cipher_high !== head_w.hi) begin
                    mismatches++;
                    $display("%0t cipher_high mismatch: expected %h actual %h", $time,
                             head_w.hi, blk_out.cipher_high);
                end
                if (blk_out.cipher_low !== head_w.lo) begin
                    mismatches++;
                    $display("%0t cipher_low mismatch: expected %h actual %h", $time,
                             head_w.lo, blk_out.cipher_low);
                end
                if (blk_out.last_result !== head_w.last) begin
                    mismatches++;
                    $display("%0t last_result mismatch: expected %b actual %b", $time,
                             head_w.last, blk_out.last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = sm4cbc_pkg::CFG_KEY_HIGH;
        cfg_data = '0;
        blk_in.valid = 1'b0;
        blk_in.plain_high = '0;
        blk_in.plain_low = '0;
        blk_in.valid_bytes = '0;
        blk_in.last_block = 1'b0;
        key_hi_cfg = '0;
        key_lo_cfg = '0;
        iv_hi_cfg = '0;
        iv_lo_cfg = '0;
        keys_valid = 1'b0;
        msg_first = 1'b1;
        chain_blk = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_field_extremes();
        test_padding_rules();
        test_midmessage_config();
        test_drain_pause();
        test_random_traffic();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/sm4cbc_pkg.sv
design/sm4cbc_intf.sv
design/sm4cbc_ctrl.sv
design/sm4cbc_datapath.sv
design/sm4_cbc_encryptor.sv
tb/tb_sm4_cbc_encryptor.sv
